// ----- sv/pane_pkg.sv -----
package pane_pkg;

   // coordinate format: signed fixed point with 8 fraction bits
   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 8;
   localparam int IPART_W    = COORD_BITS - FRAC_BITS;

   // result field widths
   localparam int AREA_W = 57;
   localparam int NORM_W = 2 * COORD_BITS + 2;

   // stream payload widths
   localparam int REQ_TDATA_W = 3 * COORD_BITS;
   localparam int RSP_FIELD_W = AREA_W + 3 * NORM_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef logic signed [COORD_BITS-1:0]   coord_type;
   typedef logic signed [COORD_BITS:0]     psum_type;
   typedef logic signed [2*COORD_BITS+1:0] prod_type;
   typedef logic signed [NORM_W:0]         ndiff_type;
   typedef logic signed [NORM_W-1:0]       norm_type;
   typedef logic signed [IPART_W-1:0]      ipart_type;

   // result flags, packed from the lowest bit up: normal_valid, level_in_y, too_many
   typedef struct packed {
      logic too_many;
      logic level_in_y;
      logic normal_valid;
   } flags_type;

   localparam int RSP_TUSER_W = $bits(flags_type);

   // integer part, truncated toward zero
   function automatic ipart_type int_part(input coord_type v);
      ipart_type q;
      q = IPART_W'(v >>> FRAC_BITS);
      if (v[COORD_BITS-1] && (v[FRAC_BITS-1:0] != '0)) begin
         q = q + IPART_W'(1);
      end
      return q;
   endfunction

   // clamp a one-bit-wider difference to the normal range
   function automatic norm_type sat_norm(input ndiff_type v);
      norm_type r;
      if (v[NORM_W] != v[NORM_W-1]) begin
         r = v[NORM_W] ? {1'b1, {(NORM_W-1){1'b0}}} : {1'b0, {(NORM_W-1){1'b1}}};
      end else begin
         r = v[NORM_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/polygon_area_normal_engine_unit.sv -----
// result path: the last vertex of a polygon passes stages 1 to 4 and then loads the output register
// throughput: one vertex per cycle; input stalls only while a finished result waits
//    on the output register and the next polygon's last vertex reaches the final stage
// reset: synchronous, active high; clears the pipeline valids and the polygon state
//    (count, accumulator, level and overflow flags)
module polygon_area_normal_engine_unit #(
   parameter int MAX_VERTICES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // vertex stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pane_pkg::REQ_TDATA_W-1:0]    req_tdata,  // vertex_x, vertex_y, vertex_z
   input  logic                                req_tlast,  // last_vertex
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pane_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // area, normal_x, normal_y,
                                                           // normal_z, zero pad
   output logic [pane_pkg::RSP_TUSER_W-1:0]    rsp_tuser   // normal_valid, level_in_y,
                                                           // too_many
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   // every edge term fits 2*COORD_BITS+1 bits; up to MAX_VERTICES+1 terms per polygon
   localparam int SUM_W = 2 * pane_pkg::COORD_BITS + 2 + CNT_W;

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam int CB = pane_pkg::COORD_BITS;

   // ---------------------------------------------------------------------------------
   // pipeline enable: everything moves unless a finished result would be overwritten
   // ---------------------------------------------------------------------------------
   logic s4_v_ff, s4_last_ff, rsp_v_ff;
   logic hold, en;

   assign hold       = s4_v_ff && s4_last_ff && rsp_v_ff && !rsp_tready;
   assign en         = !hold;
   assign req_tready = en;

   // ---------------------------------------------------------------------------------
   // stage 1: input register
   // ---------------------------------------------------------------------------------
   logic                s1_v_ff, s1_last_ff;
   pane_pkg::coord_type s1_x_ff, s1_y_ff, s1_z_ff;

   // polygon state, updated as each stage 1 vertex moves on
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                same_ff, same_in;
   logic                ovf_ff, ovf_in;
   pane_pkg::coord_type prev_x_ff, prev_y_ff, prev_z_ff;
   pane_pkg::coord_type prev_x_in, prev_y_in, prev_z_in;
   pane_pkg::coord_type fx_ff [3];
   pane_pkg::coord_type fy_ff [3];
   pane_pkg::coord_type fz_ff [3];
   pane_pkg::coord_type fx_in [3];
   pane_pkg::coord_type fy_in [3];
   pane_pkg::coord_type fz_in [3];

   logic                kept, edge_on, close_on, lvl_miss;
   logic [CNT_W-1:0]    cnt_upd;
   pane_pkg::flags_type s1_flags;

   always_comb begin
      // a vertex past the limit is dropped but still flags overflow
      kept     = cnt_ff < CNT_W'(MAX_VERTICES);
      edge_on  = kept && (cnt_ff != '0);
      lvl_miss = pane_pkg::int_part(s1_y_ff) != pane_pkg::int_part(prev_y_ff);
      cnt_upd  = kept ? cnt_ff + CNT_W'(1) : cnt_ff;
      close_on = cnt_upd != '0;

      for (int i = 0; i < 3; i++) begin
         if (kept && (cnt_ff == CNT_W'(i))) begin
            fx_in[i] = s1_x_ff;
            fy_in[i] = s1_y_ff;
            fz_in[i] = s1_z_ff;
         end else begin
            fx_in[i] = fx_ff[i];
            fy_in[i] = fy_ff[i];
            fz_in[i] = fz_ff[i];
         end
      end

      prev_x_in = kept ? s1_x_ff : prev_x_ff;
      prev_y_in = kept ? s1_y_ff : prev_y_ff;
      prev_z_in = kept ? s1_z_ff : prev_z_ff;

      s1_flags.normal_valid = cnt_upd >= CNT_W'(3);
      s1_flags.level_in_y   = same_ff && !(edge_on && lvl_miss);
      s1_flags.too_many     = ovf_ff || !kept;

      // polygon end returns the state to its reset values
      if (s1_last_ff) begin
         cnt_in  = '0;
         same_in = 1'b1;
         ovf_in  = 1'b0;
      end else begin
         cnt_in  = cnt_upd;
         same_in = s1_flags.level_in_y;
         ovf_in  = s1_flags.too_many;
      end
   end

   // ---------------------------------------------------------------------------------
   // stage 2: multiplier operands
   // ---------------------------------------------------------------------------------
   logic                s2_v_ff, s2_last_ff, s2_edge_ff, s2_close_ff;
   pane_pkg::psum_type  s2_ea_ff, s2_eb_ff, s2_ca_ff, s2_cb_ff;
   pane_pkg::psum_type  s2_a1_ff, s2_b1_ff, s2_c1_ff, s2_a2_ff, s2_b2_ff, s2_c2_ff;
   pane_pkg::flags_type s2_flags_ff;

   // ---------------------------------------------------------------------------------
   // stage 3: products
   // ---------------------------------------------------------------------------------
   logic                s3_v_ff, s3_last_ff;
   pane_pkg::prod_type  s3_ep_ff, s3_cp_ff;
   pane_pkg::prod_type  s3_n1_ff, s3_n2_ff, s3_n3_ff, s3_n4_ff, s3_n5_ff, s3_n6_ff;
   pane_pkg::flags_type s3_flags_ff;

   // ---------------------------------------------------------------------------------
   // stage 4: shoelace accumulator and normal differences
   // ---------------------------------------------------------------------------------
   sum_type             acc_ff, acc_in, tot;
   sum_type             s4_tot_ff;
   pane_pkg::norm_type  s4_nx_ff, s4_ny_ff, s4_nz_ff;
   pane_pkg::flags_type s4_flags_ff;

   assign tot    = acc_ff + sum_type'(s3_ep_ff) + sum_type'(s3_cp_ff);
   assign acc_in = s3_last_ff ? '0 : tot;

   // ---------------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------------
   logic [SUM_W-1:0]        mag;
   logic [pane_pkg::AREA_W-1:0] rsp_area_ff;
   pane_pkg::norm_type      rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   pane_pkg::flags_type     rsp_flags_ff;

   assign mag = s4_tot_ff[SUM_W-1] ? SUM_W'(-s4_tot_ff) : SUM_W'(s4_tot_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         cnt_ff   <= '0;
         same_ff  <= 1'b1;
         ovf_ff   <= 1'b0;
         acc_ff   <= '0;
      end else begin
         if (en) begin
            s1_v_ff <= req_tvalid;
            s2_v_ff <= s1_v_ff;
            s3_v_ff <= s2_v_ff;
            s4_v_ff <= s3_v_ff;
            if (s1_v_ff) begin
               cnt_ff  <= cnt_in;
               same_ff <= same_in;
               ovf_ff  <= ovf_in;
            end
            if (s3_v_ff) begin
               acc_ff <= acc_in;
            end
         end
         if (en && s4_v_ff && s4_last_ff) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1
         s1_x_ff    <= req_tdata[CB-1:0];
         s1_y_ff    <= req_tdata[2*CB-1:CB];
         s1_z_ff    <= req_tdata[3*CB-1:2*CB];
         s1_last_ff <= req_tlast;
         if (s1_v_ff) begin
            prev_x_ff <= prev_x_in;
            prev_y_ff <= prev_y_in;
            prev_z_ff <= prev_z_in;
            fx_ff     <= fx_in;
            fy_ff     <= fy_in;
            fz_ff     <= fz_in;
         end

         // stage 2: edge (x + x_prev) * (z_prev - z), closing edge back to the first vertex
         s2_last_ff  <= s1_last_ff;
         s2_edge_ff  <= edge_on;
         s2_close_ff <= s1_last_ff && close_on;
         s2_ea_ff    <= pane_pkg::psum_type'(s1_x_ff) + pane_pkg::psum_type'(prev_x_ff);
         s2_eb_ff    <= pane_pkg::psum_type'(prev_z_ff) - pane_pkg::psum_type'(s1_z_ff);
         s2_ca_ff    <= pane_pkg::psum_type'(fx_in[0]) + pane_pkg::psum_type'(prev_x_in);
         s2_cb_ff    <= pane_pkg::psum_type'(prev_z_in) - pane_pkg::psum_type'(fz_in[0]);
         s2_a1_ff    <= pane_pkg::psum_type'(fx_in[1]) - pane_pkg::psum_type'(fx_in[0]);
         s2_b1_ff    <= pane_pkg::psum_type'(fy_in[1]) - pane_pkg::psum_type'(fy_in[0]);
         s2_c1_ff    <= pane_pkg::psum_type'(fz_in[1]) - pane_pkg::psum_type'(fz_in[0]);
         s2_a2_ff    <= pane_pkg::psum_type'(fx_in[2]) - pane_pkg::psum_type'(fx_in[0]);
         s2_b2_ff    <= pane_pkg::psum_type'(fy_in[2]) - pane_pkg::psum_type'(fy_in[0]);
         s2_c2_ff    <= pane_pkg::psum_type'(fz_in[2]) - pane_pkg::psum_type'(fz_in[0]);
         s2_flags_ff <= s1_flags;

         // stage 3: one 25 x 25 multiply per product
         s3_last_ff  <= s2_last_ff;
         s3_ep_ff    <= s2_edge_ff ?
                        pane_pkg::prod_type'(s2_ea_ff) * pane_pkg::prod_type'(s2_eb_ff) : '0;
         s3_cp_ff    <= s2_close_ff ?
                        pane_pkg::prod_type'(s2_ca_ff) * pane_pkg::prod_type'(s2_cb_ff) : '0;
         s3_n1_ff    <= pane_pkg::prod_type'(s2_b1_ff) * pane_pkg::prod_type'(s2_c2_ff);
         s3_n2_ff    <= pane_pkg::prod_type'(s2_b2_ff) * pane_pkg::prod_type'(s2_c1_ff);
         s3_n3_ff    <= pane_pkg::prod_type'(s2_a2_ff) * pane_pkg::prod_type'(s2_c1_ff);
         s3_n4_ff    <= pane_pkg::prod_type'(s2_a1_ff) * pane_pkg::prod_type'(s2_c2_ff);
         s3_n5_ff    <= pane_pkg::prod_type'(s2_a1_ff) * pane_pkg::prod_type'(s2_b2_ff);
         s3_n6_ff    <= pane_pkg::prod_type'(s2_b1_ff) * pane_pkg::prod_type'(s2_a2_ff);
         s3_flags_ff <= s2_flags_ff;

         // stage 4: running total, cross-product differences with clamping
         s4_last_ff  <= s3_last_ff;
         s4_tot_ff   <= tot;
         s4_flags_ff <= s3_flags_ff;
         if (s3_flags_ff.normal_valid) begin
            s4_nx_ff <= pane_pkg::sat_norm(pane_pkg::ndiff_type'(s3_n1_ff)
                                           - pane_pkg::ndiff_type'(s3_n2_ff));
            s4_ny_ff <= pane_pkg::sat_norm(pane_pkg::ndiff_type'(s3_n3_ff)
                                           - pane_pkg::ndiff_type'(s3_n4_ff));
            s4_nz_ff <= pane_pkg::sat_norm(pane_pkg::ndiff_type'(s3_n5_ff)
                                           - pane_pkg::ndiff_type'(s3_n6_ff));
         end else begin
            s4_nx_ff <= '0;
            s4_ny_ff <= '0;
            s4_nz_ff <= '0;
         end

         // output: area is half the magnitude, truncated
         if (s4_v_ff && s4_last_ff) begin
            rsp_area_ff  <= pane_pkg::AREA_W'(mag >> 1);
            rsp_nx_ff    <= s4_nx_ff;
            rsp_ny_ff    <= s4_ny_ff;
            rsp_nz_ff    <= s4_nz_ff;
            rsp_flags_ff <= s4_flags_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{pane_pkg::RSP_PAD_W{1'b0}}, rsp_nz_ff, rsp_ny_ff, rsp_nx_ff,
                        rsp_area_ff};
   assign rsp_tuser  = rsp_flags_ff;

   // ---------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------
   // polygon state is cleared once its last vertex moves past stage 1
   a_state_cleared : assert property (@(posedge clock) disable iff (reset)
      (en && s1_v_ff && s1_last_ff) |=> (cnt_ff == '0) && same_ff && !ovf_ff)
      else $error("polygon state not cleared after last vertex");

   // the kept vertex count never passes the limit
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count above limit");

   // overflow is only flagged with the count at its limit
   a_ovf_at_limit : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (cnt_ff == CNT_W'(MAX_VERTICES)))
      else $error("overflow flag without full count");

   // input backpressure only while a result waits on the output
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_v_ff)
      else $error("input stalled with empty output register");

   // a last vertex leaving stage 4 always shows up as a result
   a_result_issued : assert property (@(posedge clock) disable iff (reset)
      (en && s4_v_ff && s4_last_ff) |=> rsp_v_ff)
      else $error("result lost at output register");

endmodule
